// ===== hdl/dss_pkg.sv =====
// Shared types and constants for the dual stack block.
// Used by dss_ctrl, dss_datapath and dual_stack_shared_array; no dependencies.
`default_nettype none

package dss_pkg;

  localparam int DEPTH  = 16;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int CMD_W  = 4;
  localparam int STS_W  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 4'd0,
    CMD_PUSH1 = 4'd1,
    CMD_PUSH2 = 4'd2,
    CMD_POP1  = 4'd3,
    CMD_POP2  = 4'd4,
    CMD_PEEK1 = 4'd5,
    CMD_PEEK2 = 4'd6,
    CMD_LIST1 = 4'd7,
    CMD_LIST2 = 4'd8
  } cmd_t;

  typedef enum logic [STS_W-1:0] {
    ST_OK    = 2'd0,
    ST_OVER  = 2'd1,
    ST_UNDER = 2'd2
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic    load;        // capture the request
    logic    clear;       // empty both stacks
    logic    push;        // write and bump the selected count
    logic    rd_top;      // read the selected top entry
    logic    pop;         // drop the selected count
    logic    list_start;  // set up the list walk
    logic    list_step;   // read one entry of the walk
    logic    emit;        // emit a result with zero value
    status_t emit_status;
  } dp_ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic is_known;
    logic is_clear;
    logic is_push;
    logic is_pop;
    logic is_list;
    logic empty;
    logic full;
    logic list_final;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== hdl/dual_stack_shared_array.sv =====
// Two stacks in one shared store: top level joining controller and datapath.
// Depends on dss_pkg, dss_ctrl and dss_datapath.
//
// A request is taken on a rising edge with start high and busy low. Clear,
// push and the error cases are captured, then executed; pop and peek read the
// top entry at execute, and the result passes the registered store read and
// then the result registers. A list of N entries keeps busy high from capture
// through the walk, one store read per cycle through the single read port,
// and streams N results one per cycle. Each result sits on
// the out_ ports for exactly one cycle with out_valid high; there is no back
// pressure, so the receiver must take every result as it comes. Undefined
// command codes are swallowed without a result. The store has no reset.
`default_nettype none

module dual_stack_shared_array
  import dss_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [CMD_W-1:0]         in_command,
  input  wire logic signed [DATA_W-1:0] in_push_value,
  output logic                          out_valid,
  output logic signed [DATA_W-1:0]      out_read_value,
  output logic [STS_W-1:0]              out_status,
  output logic                          out_last
);

  dp_ctl_t ctl;
  dp_sts_t sts;

  // sequencing: one request at a time
  dss_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy)
  );

  // store, counts and result registers
  dss_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_command     (in_command),
    .in_push_value  (in_push_value),
    .ctl            (ctl),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_read_value (out_read_value),
    .out_status     (out_status),
    .out_last       (out_last)
  );

endmodule

`default_nettype wire

// ===== hdl/dss_datapath.sv =====
// Datapath: shared store, stack counts, read pipe and result registers.
// Depends on dss_pkg; driven by dss_ctrl.
`default_nettype none

module dss_datapath
  import dss_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic [CMD_W-1:0]         in_command,
  input  wire logic signed [DATA_W-1:0] in_push_value,
  input  wire dp_ctl_t                  ctl,
  output dp_sts_t                       sts,
  output logic                          out_valid,
  output logic signed [DATA_W-1:0]      out_read_value,
  output logic [STS_W-1:0]              out_status,
  output logic                          out_last
);

  logic [DATA_W-1:0] mem [DEPTH];

  logic [CMD_W-1:0]  cmd_r;
  logic [DATA_W-1:0] val_r;
  logic [CNT_W-1:0]  low_cnt_r, low_cnt_nxt;
  logic [CNT_W-1:0]  high_cnt_r, high_cnt_nxt;
  logic [ADDR_W-1:0] addr_r;
  logic [CNT_W-1:0]  remain_r;
  logic [DATA_W-1:0] rd_data_r;
  logic              rd_vld_r;
  logic              rd_last_r;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_value_r;
  logic [STS_W-1:0]  out_status_r;
  logic              out_last_r;

  logic              high_sel;
  logic [CNT_W-1:0]  sel_cnt;
  logic [CNT_W-1:0]  low_top, high_top, high_free;
  logic [CNT_W:0]    used;
  logic [ADDR_W-1:0] top_addr, wr_addr, rd_addr;
  logic              rd_en;

  always_comb begin
    high_sel = (cmd_r inside {CMD_PUSH2, CMD_POP2, CMD_PEEK2, CMD_LIST2});
    sel_cnt  = high_sel ? high_cnt_r : low_cnt_r;
    used     = {1'b0, low_cnt_r} + {1'b0, high_cnt_r};
    // top of stack one sits below its count, top of stack two at DEPTH-count
    low_top   = low_cnt_r - CNT_W'(1);
    high_top  = CNT_W'(DEPTH) - high_cnt_r;
    high_free = CNT_W'(DEPTH - 1) - high_cnt_r;
    top_addr  = high_sel ? high_top[ADDR_W-1:0] : low_top[ADDR_W-1:0];
    wr_addr   = high_sel ? high_free[ADDR_W-1:0] : low_cnt_r[ADDR_W-1:0];
    rd_addr   = ctl.list_step ? addr_r : top_addr;
    rd_en     = ctl.rd_top | ctl.list_step;

    sts.is_known   = (cmd_r inside {[CMD_CLEAR:CMD_LIST2]});
    sts.is_clear   = (cmd_r == CMD_CLEAR);
    sts.is_push    = (cmd_r inside {CMD_PUSH1, CMD_PUSH2});
    sts.is_pop     = (cmd_r inside {CMD_POP1, CMD_POP2});
    sts.is_list    = (cmd_r inside {CMD_LIST1, CMD_LIST2});
    sts.empty      = (sel_cnt == '0);
    sts.full       = (used >= (CNT_W + 1)'(DEPTH));
    sts.list_final = (remain_r == CNT_W'(1));
  end

  always_comb begin
    low_cnt_nxt  = low_cnt_r;
    high_cnt_nxt = high_cnt_r;
    if (ctl.clear) begin
      low_cnt_nxt  = '0;
      high_cnt_nxt = '0;
    end else if (ctl.push) begin
      if (high_sel) high_cnt_nxt = high_cnt_r + CNT_W'(1);
      else          low_cnt_nxt  = low_cnt_r + CNT_W'(1);
    end else if (ctl.pop) begin
      if (high_sel) high_cnt_nxt = high_cnt_r - CNT_W'(1);
      else          low_cnt_nxt  = low_cnt_r - CNT_W'(1);
    end
  end

  // store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[wr_addr] <= val_r;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r <= in_command;
      val_r <= in_push_value;
    end
    if (ctl.list_start) begin
      addr_r   <= top_addr;
      remain_r <= sel_cnt;
    end else if (ctl.list_step) begin
      addr_r   <= high_sel ? addr_r + ADDR_W'(1) : addr_r - ADDR_W'(1);
      remain_r <= remain_r - CNT_W'(1);
    end
    rd_last_r    <= ctl.rd_top | sts.list_final;
    out_value_r  <= rd_vld_r ? rd_data_r : '0;
    out_status_r <= rd_vld_r ? ST_OK : ctl.emit_status;
    out_last_r   <= rd_vld_r ? rd_last_r : 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_cnt_r   <= '0;
      high_cnt_r  <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      low_cnt_r   <= low_cnt_nxt;
      high_cnt_r  <= high_cnt_nxt;
      rd_vld_r    <= rd_en;
      out_valid_r <= rd_vld_r | ctl.emit;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_value_r;
  assign out_status     = out_status_r;
  assign out_last       = out_last_r;

  a_no_overcommit: assert property (@(posedge clk) disable iff (!rst_n)
    used <= (CNT_W + 1)'(DEPTH))
    else $error("stack counts exceed store depth");

  a_no_result_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_vld_r && ctl.emit))
    else $error("read data and direct result in the same cycle");

  a_read_emits: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |=> out_valid && (out_status == ST_OK))
    else $error("read data not emitted");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.push |=> used == $past(used) + (CNT_W + 1)'(1))
    else $error("push did not grow the stacks");

endmodule

`default_nettype wire

// ===== hdl/dss_ctrl.sv =====
// Controller: sequences each request through decode, store access and list walk.
// Depends on dss_pkg; drives dss_datapath.
`default_nettype none

module dss_ctrl
  import dss_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  input  wire dp_sts_t sts,
  output dp_ctl_t      ctl,
  output logic         busy
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LIST
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    state_nxt       = state_r;
    ctl             = '0;
    ctl.emit_status = ST_OK;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        if (!sts.is_known) begin
          // undefined codes: no result, no change
        end else if (sts.is_clear) begin
          ctl.clear = 1'b1;
          ctl.emit  = 1'b1;
        end else if (sts.is_push) begin
          ctl.emit = 1'b1;
          if (sts.full) ctl.emit_status = ST_OVER;
          else          ctl.push        = 1'b1;
        end else if (sts.empty) begin
          ctl.emit        = 1'b1;
          ctl.emit_status = ST_UNDER;
        end else if (sts.is_list) begin
          ctl.list_start = 1'b1;
          state_nxt      = S_LIST;
        end else begin
          ctl.rd_top = 1'b1;
          ctl.pop    = sts.is_pop;
        end
      end
      S_LIST: begin
        ctl.list_step = 1'b1;
        if (sts.list_final) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

`default_nettype wire
